// File: rtl/core/sfbpc_pkg.sv
// shared types and constants for the boiler phase controller
// no dependencies
package sfbpc_pkg;

   localparam int HistoryDepthDefault   = 8;
   localparam int RoutinePeriodDefault  = 30;
   localparam int SamplePeriodDefault   = 60;
   localparam int ManualTimeoutDefault  = 900;

   localparam logic signed [15:0] TEMP_SENSOR_ERR = -16'sd2032;
   localparam logic signed [15:0] TEMP_RESET      = 16'sd320;
   localparam logic signed [15:0] TEMP_FLUE_HI    = 16'sd4160;
   localparam logic signed [15:0] TEMP_FLUE_LO    = 16'sd3200;
   localparam int T30 = 480;
   localparam int T5  = 80;
   localparam int T2  = 32;
   localparam logic [15:0] KINDLE_LIMIT_S = 16'd900;
   localparam logic [15:0] FAN_LIMIT_S    = 16'd600;

   typedef enum logic [2:0] {
      OP_WATER = 3'd0, OP_FLUE = 3'd1, OP_TICK = 3'd2, OP_MODE = 3'd3,
      OP_TRIGGER = 3'd4, OP_FAN_TOGGLE = 3'd5, OP_PUMP_TOGGLE = 3'd6, OP_KINDLE = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      PH_UNKNOWN = 3'd0, PH_OUT = 3'd1, PH_KINDLING = 3'd2, PH_BURNING = 3'd3,
      PH_DYING = 3'd4
   } phase_type;

   localparam logic [1:0] TR_STABLE  = 2'd0;
   localparam logic [1:0] TR_RISING  = 2'd1;
   localparam logic [1:0] TR_FALLING = 2'd2;

   localparam logic [1:0] ST_OFF    = 2'd0;
   localparam logic [1:0] ST_ON     = 2'd1;
   localparam logic [1:0] ST_MANUAL = 2'd2;

   localparam logic [2:0] REG_TARGET   = 3'd0;
   localparam logic [2:0] REG_HYST     = 3'd1;
   localparam logic [2:0] REG_THRESH   = 3'd2;
   localparam logic [2:0] REG_FLUE_EN  = 3'd3;
   localparam logic [2:0] REG_CUTOFF   = 3'd4;
   localparam logic [2:0] REG_PUMP_REL = 3'd5;
   localparam logic [2:0] REG_FAN_REL  = 3'd6;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic       load;      // latch the request
      logic       event_run; // apply the event and start a history pass
      logic       hist_step; // one history shift/fill step
      logic       trend_eval;
      logic       routine;   // run the phase routine
   } cmd_type;

   typedef struct packed {
      logic need_sample; // the tick wants a history sample
      logic need_routine;
      logic hist_last;   // last history step this pass
   } stat_type;

endpackage

// File: rtl/core/sfbpc_ctrl.sv
// sequencer for the boiler phase controller: steps each transfer through event,
// history and trend when sampling, routine when due, and result; uses sfbpc_pkg
module sfbpc_ctrl
   import sfbpc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_fire,
   input  logic     out_free,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     req_ready,
   output logic     out_load
);

   typedef enum logic [2:0] {
      S_IDLE, S_EVENT, S_HIST, S_TREND, S_ROUTINE, S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      out_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            cmd.load = req_fire;
            if (req_fire) state_in = S_EVENT;
         end
         S_EVENT: begin
            cmd.event_run = 1'b1;
            if (stat.need_sample) state_in = S_HIST;
            else if (stat.need_routine) state_in = S_ROUTINE;
            else state_in = S_DONE;
         end
         S_HIST: begin
            cmd.hist_step = 1'b1;
            if (stat.hist_last) state_in = S_TREND;
         end
         S_TREND: begin
            cmd.trend_eval = 1'b1;
            state_in = stat.need_routine ? S_ROUTINE : S_DONE;
         end
         S_ROUTINE: begin
            cmd.routine = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// File: rtl/core/sfbpc_hist.sv
// water temperature history with running half sums and trend
// one entry shifted per cycle while step is high; uses sfbpc_pkg
module sfbpc_hist
   import sfbpc_pkg::*;
#(
   parameter int HISTORY_DEPTH = HistoryDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,      // begin a sample pass
   input  logic               step,
   input  logic               trend_eval,
   input  logic signed [15:0] sample,
   output logic               last,
   output logic [1:0]         trend
);

   localparam int C1 = HISTORY_DEPTH / 2;
   localparam int C2 = HISTORY_DEPTH - HISTORY_DEPTH / 2;
   localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int SW = 16 + IW + 1;
   localparam int PW = SW + 8;

   logic signed [15:0] hist_ff [HISTORY_DEPTH];
   logic               filled_ff, filled_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic signed [SW-1:0] s1_ff, s1_in, s2_ff, s2_in;
   logic [1:0]         trend_ff, trend_in;
   logic signed [15:0] next_val;
   logic signed [PW-1:0] p1, p2;

   assign last = (idx_ff == IW'(HISTORY_DEPTH - 1));

   // value that lands at idx_ff in this step
   always_comb begin
      if (!filled_ff || idx_ff == IW'(HISTORY_DEPTH - 1)) next_val = sample;
      else next_val = hist_ff[idx_ff + IW'(1)];
   end

   always_comb begin
      idx_in    = idx_ff;
      s1_in     = s1_ff;
      s2_in     = s2_ff;
      filled_in = filled_ff;
      if (start) begin
         idx_in = '0;
         s1_in  = '0;
         s2_in  = '0;
      end else if (step) begin
         if (idx_ff < IW'(C1)) s1_in = s1_ff + SW'(next_val);
         else s2_in = s2_ff + SW'(next_val);
         if (last) filled_in = 1'b1;
         else idx_in = idx_ff + IW'(1);
      end
   end

   assign p1 = PW'(s1_ff) * PW'(C2);
   assign p2 = PW'(s2_ff) * PW'(C1);

   always_comb begin
      trend_in = trend_ff;
      if (trend_eval) begin
         if (p1 < p2) trend_in = TR_RISING;
         else if (p1 > p2) trend_in = TR_FALLING;
         else trend_in = TR_STABLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= 1'b0;
         trend_ff  <= TR_STABLE;
         idx_ff    <= '0;
      end else begin
         filled_ff <= filled_in;
         trend_ff  <= trend_in;
         idx_ff    <= idx_in;
      end
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      if (step) hist_ff[idx_ff] <= next_val;
   end

   assign trend = trend_ff;

endmodule

// File: rtl/core/sfbpc_dp.sv
// datapath: event handling, timers, phase rules and relay state
// uses sfbpc_pkg and sfbpc_hist
module sfbpc_dp
   import sfbpc_pkg::*;
#(
   parameter int HISTORY_DEPTH    = HistoryDepthDefault,
   parameter int ROUTINE_PERIOD_S = RoutinePeriodDefault,
   parameter int SAMPLE_PERIOD_S  = SamplePeriodDefault,
   parameter int MANUAL_TIMEOUT_S = ManualTimeoutDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [2:0]         req_op,
   input  logic signed [15:0] req_temp,
   input  logic               req_level,
   input  logic               csr_we,
   input  logic [2:0]         csr_idx,
   input  logic [10:0]        csr_data,
   output logic [15:0]        result
);

   logic [10:0] tgt_ff, thr_ff;
   logic [8:0]  hys_ff;
   logic flue_en_ff, cutoff_ff, pump_rel_ff, fan_rel_ff;

   op_type             op_ff;
   logic signed [15:0] t_ff;
   logic               lvl_ff;
   logic               need_s_ff, need_r_ff;

   phase_type  phase_ff, phase_in;
   logic signed [15:0] water_ff, water_in, flue_ff, flue_in;
   logic winter_ff, winter_in, trig_ff, trig_in;
   logic pa_ff, pa_in, fa_ff, fa_in, pm_ff, pm_in, fm_ff, fm_in;
   logic fb_ff, fb_in, fw_ff, fw_in, te_ff, te_in, tc_ff, tc_in;
   logic [1:0] ps_ff, ps_in, fs_ff, fs_in;
   logic [15:0] ks_ff, ks_in, fr_ff, fr_in;
   logic [10:0] fms_ff, fms_in, pms_ff, pms_in;
   logic [7:0]  rs_ff, rs_in, ss_ff, ss_in;
   logic        ns_in, nr_in;
   logic [1:0]  trend;
   logic        hist_last;

   sfbpc_hist #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_hist (
      .clock(clock), .reset(reset), .start(cmd.event_run), .step(cmd.hist_step),
      .trend_eval(cmd.trend_eval), .sample(water_ff), .last(hist_last), .trend(trend)
   );

   assign stat.need_sample  = need_s_ff;
   assign stat.need_routine = need_r_ff;
   assign stat.hist_last    = hist_last;

   // widened signed comparison operands
   logic signed [17:0] w, tgt, hys, thr, fl;
   assign w   = 18'(water_ff);
   assign fl  = 18'(flue_ff);
   assign tgt = $signed({7'd0, tgt_ff});
   assign hys = $signed({9'd0, hys_ff});
   assign thr = $signed({7'd0, thr_ff});

   always_comb begin
      logic rising, falling, running, done;
      logic [8:0] rsi;
      rising  = (trend == TR_RISING);
      falling = (trend == TR_FALLING);
      phase_in = phase_ff; water_in = water_ff; flue_in = flue_ff;
      winter_in = winter_ff; trig_in = trig_ff;
      pa_in = pa_ff; fa_in = fa_ff; pm_in = pm_ff; fm_in = fm_ff;
      fb_in = fb_ff; fw_in = fw_ff; te_in = te_ff; tc_in = tc_ff;
      ps_in = ps_ff; fs_in = fs_ff; ks_in = ks_ff; fr_in = fr_ff;
      fms_in = fms_ff; pms_in = pms_ff; rs_in = rs_ff; ss_in = ss_ff;
      ns_in = need_s_ff; nr_in = need_r_ff;
      running = 1'b0; done = 1'b0;
      rsi = (rs_ff == 8'hFF) ? {1'b0, rs_ff} : {1'b0, rs_ff} + 9'd1;

      // decide the passes at the transfer so the sequencer sees them in the event cycle
      if (cmd.load) begin
         ns_in = (op_type'(req_op) == OP_TICK) && (ss_ff == '0);
         case (op_type'(req_op))
            OP_WATER: nr_in = (req_temp != TEMP_SENSOR_ERR);
            OP_TICK:  nr_in = (rsi >= 9'(ROUTINE_PERIOD_S));
            OP_MODE:  nr_in = (req_level != winter_ff);
            default:  nr_in = 1'b0;
         endcase
      end

      if (cmd.event_run) begin
         case (op_ff)
            OP_WATER: begin
               if (t_ff != TEMP_SENSOR_ERR) begin
                  water_in = t_ff; rs_in = '0;
               end
            end
            OP_FLUE: begin
               flue_in = t_ff;
               if (cutoff_ff) begin
                  if (t_ff >= TEMP_FLUE_HI && !fb_ff) begin
                     if (fa_ff) begin
                        fa_in = 1'b0;
                        if (fan_rel_ff && !fm_ff) fs_in = ST_OFF;
                     end
                     fb_in = 1'b1;
                  end
                  if (t_ff <= TEMP_FLUE_LO && fb_ff) begin
                     fb_in = 1'b0;
                     if (fw_ff && !fa_ff) begin
                        fa_in = 1'b1; fr_in = '0;
                        if (fan_rel_ff) fs_in = ST_ON;
                     end
                  end
               end
            end
            OP_TICK: begin
               ks_in = (ks_ff == 16'hFFFF) ? ks_ff : ks_ff + 16'd1;
               fr_in = (fr_ff == 16'hFFFF) ? fr_ff : fr_ff + 16'd1;
               if (ss_ff == '0) begin
                  ss_in = 8'(SAMPLE_PERIOD_S - 1);
               end else ss_in = ss_ff - 8'd1;
               if (fm_ff) begin
                  fms_in = (fms_ff == 11'h7FF) ? fms_ff : fms_ff + 11'd1;
                  if (fms_in >= 11'(MANUAL_TIMEOUT_S)) begin
                     fm_in = 1'b0;
                     fs_in = (!fa_ff && fan_rel_ff) ? ST_OFF : ST_ON;
                  end
               end
               if (pm_ff) begin
                  pms_in = (pms_ff == 11'h7FF) ? pms_ff : pms_ff + 11'd1;
                  if (pms_in >= 11'(MANUAL_TIMEOUT_S)) begin
                     pm_in = 1'b0;
                     ps_in = (!pa_ff && pump_rel_ff) ? ST_OFF : ST_ON;
                  end
               end
               if (rsi >= 9'(ROUTINE_PERIOD_S)) begin
                  rs_in = '0;
               end else rs_in = rsi[7:0];
            end
            OP_MODE: begin
               if (lvl_ff != winter_ff) begin
                  if (!lvl_ff) te_in = 1'b1;
                  else begin tc_in = 1'b0; te_in = 1'b0; end
                  winter_in = lvl_ff;
               end
            end
            OP_TRIGGER: begin
               trig_in = lvl_ff;
               if (phase_ff == PH_DYING) begin
                  running = pm_ff || pa_ff;
                  if (!lvl_ff && running) begin
                     if (pa_ff) begin
                        fw_in = 1'b0; pa_in = 1'b0;
                        if (pump_rel_ff && !pm_ff) ps_in = ST_OFF;
                     end
                  end else if (lvl_ff && !running) begin
                     pa_in = 1'b1;
                     if (pump_rel_ff) ps_in = ST_ON;
                  end
               end
            end
            OP_FAN_TOGGLE: begin
               if (fm_ff) begin
                  fm_in = 1'b0; fs_in = (!fa_ff && fan_rel_ff) ? ST_OFF : ST_ON;
               end else begin
                  fms_in = '0; fm_in = 1'b1; fs_in = ST_MANUAL;
               end
            end
            OP_PUMP_TOGGLE: begin
               if (pm_ff) begin
                  pm_in = 1'b0; ps_in = (!pa_ff && pump_rel_ff) ? ST_OFF : ST_ON;
               end else begin
                  pms_in = '0; pm_in = 1'b1; ps_in = ST_MANUAL;
               end
            end
            default: begin
               // forced kindling, same as entering the kindling phase
               ks_in = '0;
               if (winter_ff) begin
                  if (!pa_ff) begin pa_in = 1'b1; if (pump_rel_ff) ps_in = ST_ON; end
               end else if (w < thr) begin
                  if (!pa_ff) begin pa_in = 1'b1; if (pump_rel_ff) ps_in = ST_ON; end
                  tc_in = 1'b0; te_in = 1'b0;
               end else if (pa_ff) begin
                  fw_in = 1'b0; pa_in = 1'b0;
                  if (pump_rel_ff && !pm_ff) ps_in = ST_OFF;
                  te_in = 1'b1;
               end
               fm_in = 1'b0;
               fw_in = 1'b1;
               if (!fb_ff && !fa_ff) begin
                  fa_in = 1'b1; fr_in = '0; if (fan_rel_ff) fs_in = ST_ON;
               end
               phase_in = PH_KINDLING;
            end
         endcase
      end

      if (cmd.routine) begin
         // working copies, updated in order like the rules
         logic pa, fa, pm, fw, te, tc;
         logic [1:0] ps, fs;
         logic [15:0] ks, fr;
         phase_type ph;
         logic goto_out, goto_kind, goto_burn, goto_dying;
         pa = pa_ff; fa = fa_ff; pm = pm_ff; fw = fw_ff; te = te_ff; tc = tc_ff;
         ps = ps_ff; fs = fs_ff; ks = ks_ff; fr = fr_ff; ph = phase_ff;
         goto_out = 1'b0; goto_kind = 1'b0; goto_burn = 1'b0; goto_dying = 1'b0;

         case (phase_ff)
            PH_UNKNOWN: begin
               if (w >= tgt - hys) goto_burn = 1'b1;
               else if (w >= 18'sd480 && rising) goto_kind = 1'b1;
               else if (w < 18'sd480 && !rising) goto_out = 1'b1;
               else if (w < thr && falling) goto_dying = 1'b1;
            end
            PH_OUT: if (w >= 18'sd480 && rising) goto_kind = 1'b1;
            PH_KINDLING: begin
               if (w >= thr && rising) goto_burn = 1'b1;
               else if (w < 18'sd480 && ks > KINDLE_LIMIT_S && !rising) goto_out = 1'b1;
               else if (w < thr - hys * 18'sd3 && falling && ks > KINDLE_LIMIT_S)
                  goto_dying = 1'b1;
               else if (!winter_ff) begin
                  if (w < thr && !pa) begin pa = 1'b1; if (pump_rel_ff) ps = ST_ON; end
                  else if (w >= thr && pa) begin
                     fw = 1'b0; pa = 1'b0; if (pump_rel_ff && !pm) ps = ST_OFF;
                  end
                  if (w >= thr + 18'sd80) begin te = 1'b1; tc = 1'b1; end
                  else if (w <= thr + 18'sd32) tc = 1'b0;
               end else if (!pa) begin
                  pa = 1'b1; if (pump_rel_ff) ps = ST_ON;
               end
            end
            PH_BURNING: begin
               if (w <= tgt - hys && !fa) begin
                  fw = 1'b1;
                  if (!fb_ff) begin fa = 1'b1; fr = '0; if (fan_rel_ff) fs = ST_ON; end
               end
               if (w >= tgt && fa) begin
                  if (!fb_ff) begin fa = 1'b0; if (fan_rel_ff && !fm_ff) fs = ST_OFF; end
               end
               if (w < thr && fr > FAN_LIMIT_S && falling) goto_dying = 1'b1;
               else if (flue_en_ff && fl < w + 18'sd480 && fa && falling) goto_dying = 1'b1;
               else if (!winter_ff) begin
                  if (w >= tgt + 18'sd80 && !pa) begin
                     pa = 1'b1; if (pump_rel_ff) ps = ST_ON;
                  end else if (w <= tgt && pa) begin
                     fw = 1'b0; pa = 1'b0; if (pump_rel_ff && !pm) ps = ST_OFF;
                  end
               end else if (!pa) begin
                  pa = 1'b1; if (pump_rel_ff) ps = ST_ON;
               end
            end
            PH_DYING: begin
               if (w >= thr && rising && !pa) begin
                  pa = 1'b1; if (pump_rel_ff) ps = ST_ON;
               end else if (w >= thr + 18'sd80 && rising) goto_burn = 1'b1;
               else if (w > 18'sd480 && rising) goto_kind = 1'b1;
               else begin
                  if (w < thr && pa) begin
                     fw = 1'b0; pa = 1'b0; if (pump_rel_ff && !pm) ps = ST_OFF;
                  end
                  if ((w < thr - 18'sd32 && falling) || (flue_en_ff && fl <= w))
                     goto_out = 1'b1;
               end
            end
            default: ;
         endcase

         if (goto_dying) begin
            running = pm || pa;
            if (!winter_ff) begin tc = 1'b0; te = 1'b0; end
            if (!trig_ff && running) begin
               if (pa) begin fw = 1'b0; pa = 1'b0; if (pump_rel_ff && !pm) ps = ST_OFF; end
            end else if (trig_ff && !running) begin
               pa = 1'b1; if (pump_rel_ff) ps = ST_ON;
            end
            if (!fb_ff && fa) begin fa = 1'b0; if (fan_rel_ff && !fm_ff) fs = ST_OFF; end
            ph = PH_DYING;
         end
         if (goto_out) begin
            // entering out twice is idempotent
            if (!winter_ff) begin tc = 1'b0; te = 1'b0; end
            if (pa) begin fw = 1'b0; pa = 1'b0; if (pump_rel_ff && !pm) ps = ST_OFF; end
            if (!fb_ff && fa) begin fa = 1'b0; if (fan_rel_ff && !fm_ff) fs = ST_OFF; end
            ph = PH_OUT;
         end
         if (goto_kind) begin
            ks = '0;
            if (winter_ff) begin
               if (!pa) begin pa = 1'b1; if (pump_rel_ff) ps = ST_ON; end
            end else if (w < thr) begin
               if (!pa) begin pa = 1'b1; if (pump_rel_ff) ps = ST_ON; end
               tc = 1'b0; te = 1'b0;
            end else if (pa) begin
               fw = 1'b0; pa = 1'b0; if (pump_rel_ff && !pm) ps = ST_OFF;
               te = 1'b1;
            end
            fm_in = 1'b0;
            fw = 1'b1;
            if (!fb_ff && !fa) begin fa = 1'b1; fr = '0; if (fan_rel_ff) fs = ST_ON; end
            ph = PH_KINDLING;
         end
         if (goto_burn) begin
            if (winter_ff) begin
               if (pm) begin
                  pm = 1'b0; ps = (!pa && pump_rel_ff) ? ST_OFF : ST_ON;
               end
               if (!pa && pump_rel_ff) begin pa = 1'b1; ps = ST_ON; end
            end else if (w < thr) begin
               if (!pa) begin pa = 1'b1; if (pump_rel_ff) ps = ST_ON; end
               te = 1'b0;
            end else if (pa) begin
               fw = 1'b0; pa = 1'b0; if (pump_rel_ff && !pm) ps = ST_OFF;
               te = 1'b1; tc = 1'b1;
            end
            if (w >= tgt && fa && !fb_ff) begin
               fa = 1'b0; if (fan_rel_ff && !fm_ff) fs = ST_OFF;
            end
            ph = PH_BURNING;
         end
         done = 1'b1;
         pa_in = pa; fa_in = fa; pm_in = pm; fw_in = fw; te_in = te; tc_in = tc;
         ps_in = ps; fs_in = fs; ks_in = ks; fr_in = fr; phase_in = ph;
      end
      if (done) nr_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff <= 11'd1360; hys_ff <= 9'd32; thr_ff <= 11'd960;
         flue_en_ff <= 1'b0; cutoff_ff <= 1'b0; pump_rel_ff <= 1'b0; fan_rel_ff <= 1'b0;
         phase_ff <= PH_UNKNOWN; water_ff <= TEMP_RESET; flue_ff <= TEMP_RESET;
         winter_ff <= 1'b1; trig_ff <= 1'b0;
         pa_ff <= 1'b0; fa_ff <= 1'b0; pm_ff <= 1'b0; fm_ff <= 1'b0;
         fb_ff <= 1'b0; fw_ff <= 1'b0; te_ff <= 1'b0; tc_ff <= 1'b0;
         ps_ff <= ST_OFF; fs_ff <= ST_OFF; ks_ff <= '0; fr_ff <= '0;
         fms_ff <= '0; pms_ff <= '0; rs_ff <= '0; ss_ff <= '0;
         need_s_ff <= 1'b0; need_r_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_idx)
               REG_TARGET:   tgt_ff <= csr_data;
               REG_HYST:     hys_ff <= csr_data[8:0];
               REG_THRESH:   thr_ff <= csr_data;
               REG_FLUE_EN:  flue_en_ff <= csr_data[0];
               REG_CUTOFF:   cutoff_ff <= csr_data[0];
               REG_PUMP_REL: pump_rel_ff <= csr_data[0];
               REG_FAN_REL:  fan_rel_ff <= csr_data[0];
               default: ;
            endcase
         end
         phase_ff <= phase_in; water_ff <= water_in; flue_ff <= flue_in;
         winter_ff <= winter_in; trig_ff <= trig_in;
         pa_ff <= pa_in; fa_ff <= fa_in; pm_ff <= pm_in; fm_ff <= fm_in;
         fb_ff <= fb_in; fw_ff <= fw_in; te_ff <= te_in; tc_ff <= tc_in;
         ps_ff <= ps_in; fs_ff <= fs_in; ks_ff <= ks_in; fr_ff <= fr_in;
         fms_ff <= fms_in; pms_ff <= pms_in; rs_ff <= rs_in; ss_ff <= ss_in;
         need_s_ff <= ns_in; need_r_ff <= nr_in;
      end
      if (cmd.load) begin
         op_ff <= op_type'(req_op); t_ff <= req_temp; lvl_ff <= req_level;
      end
   end

   assign result = {3'd0, tc_ff, te_ff, fs_ff, ps_ff,
                    fan_rel_ff & (fa_ff | fm_ff), pump_rel_ff & (pa_ff | pm_ff),
                    trend, phase_ff};

endmodule

// File: rtl/core/solid_fuel_boiler_phase_controller.sv
// top level of the wood-boiler phase supervisor
// depends on sfbpc_pkg, sfbpc_ctrl, sfbpc_dp (with sfbpc_hist)
//
//  channel | dir | ports                          | payload
//  req     | in  | req_tvalid/tready/tdata/tuser  | operation (tuser), temperature, level
//  rsp     | out | rsp_tvalid/tready/tdata        | phase, trend, relays, status, tank
//  csr     | in  | csr_we/csr_idx/csr_data        | register writes, no read-back
//
// an item steps through event, then history and trend when a tick samples the
// history (one entry shifted per cycle through the history), then the routine when due;
// the result sits in an output register; the next transfer is taken while it waits
// synchronous active-high reset; no clearing pass
module solid_fuel_boiler_phase_controller
   import sfbpc_pkg::*;
#(
   parameter int HISTORY_DEPTH    = HistoryDepthDefault,
   parameter int ROUTINE_PERIOD_S = RoutinePeriodDefault,
   parameter int SAMPLE_PERIOD_S  = SamplePeriodDefault,
   parameter int MANUAL_TIMEOUT_S = ManualTimeoutDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // temperature[15:0], level[16]
   input  logic [2:0]  req_tuser,  // operation[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // boiler_phase, trend, pump_relay, fan_relay,
                                   // pump_status, fan_status, tank_external_control,
                                   // tank_circulation
   input  logic        csr_we,
   input  logic [2:0]  csr_idx,
   input  logic [10:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;
   logic        out_load, out_free, idle_ready;
   logic [15:0] result;
   logic        vld_ff;
   logic [15:0] data_ff;

   assign out_free   = !vld_ff || rsp_tready;
   assign req_tready = idle_ready;

   sfbpc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_tvalid & idle_ready),
      .out_free(out_free), .stat(stat), .cmd(cmd), .req_ready(idle_ready),
      .out_load(out_load)
   );

   sfbpc_dp #(
      .HISTORY_DEPTH(HISTORY_DEPTH), .ROUTINE_PERIOD_S(ROUTINE_PERIOD_S),
      .SAMPLE_PERIOD_S(SAMPLE_PERIOD_S), .MANUAL_TIMEOUT_S(MANUAL_TIMEOUT_S)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_op(req_tuser), .req_temp(req_tdata[15:0]), .req_level(req_tdata[16]),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_data(csr_data), .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (out_load) vld_ff <= 1'b1;
      else if (rsp_tready) vld_ff <= 1'b0;
      if (out_load) data_ff <= result;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;

endmodule
